// ----- rtl/gbcb_pkg.sv -----
// shared types and constants of the clipped glyph block blitter
package gbcb_pkg;

  // glyph block geometry
  localparam int BLOCK_COLS = 6;
  localparam int BLOCK_ROWS = 12;
  localparam int MAX_ROWS   = 12;
  localparam int MASK_W     = 6;
  localparam int GLYPH_BITS = 72;

  localparam int EMIT_ROWS = (BLOCK_ROWS < MAX_ROWS) ? BLOCK_ROWS : MAX_ROWS;
  localparam int MASK_COLS = (BLOCK_COLS < MASK_W) ? BLOCK_COLS : MASK_W;
  localparam int PAD_BITS  = EMIT_ROWS * BLOCK_COLS;

  // last_row marks row BLOCK_ROWS-1, which may lie beyond the emitted rows
  localparam int   LAST_FLAG_ROW = BLOCK_ROWS - 1;
  localparam logic LAST_FLAG_ON  = (BLOCK_ROWS <= MAX_ROWS);

  // field widths
  localparam int REG_W  = 13;
  localparam int CW     = 15;   // clip edge arithmetic, signed
  localparam int OFS_W  = 6;    // lane offset, covers the block size range
  localparam int ADDR_W = 25;
  localparam int ROW_W  = 4;
  localparam int COLOR_W = 16;
  localparam int IDX_W  = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_CLIP_LEFT      = 3'd0,
    REG_CLIP_TOP       = 3'd1,
    REG_CLIP_WIDTH     = 3'd2,
    REG_CLIP_HEIGHT    = 3'd3,
    REG_SURFACE_WIDTH  = 3'd4,
    REG_SURFACE_HEIGHT = 3'd5,
    REG_ROW_PITCH      = 3'd6
  } cfg_reg_e;

  // effective clip rectangle plus pitch
  typedef struct packed {
    logic signed [CW-1:0] left;
    logic signed [CW-1:0] right;
    logic signed [CW-1:0] top;
    logic signed [CW-1:0] bottom;
    logic [REG_W-1:0]     pitch;
  } clip_t;

  // one block handed to the row emitter
  typedef struct packed {
    logic [EMIT_ROWS-1:0][MASK_W-1:0] masks;
    logic [ADDR_W-1:0]                addr;
    logic [COLOR_W-1:0]               color;
  } load_t;

endpackage

// ----- rtl/gbcb_cfg.sv -----
// configuration registers and effective clip rectangle
module gbcb_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gbcb_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [gbcb_pkg::REG_W-1:0]   cfg_data_i,
  output gbcb_pkg::clip_t              clip_o
);

  logic [gbcb_pkg::REG_W-1:0] clip_left_q, clip_top_q, clip_width_q, clip_height_q;
  logic [gbcb_pkg::REG_W-1:0] surf_width_q, surf_height_q, row_pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= '0;
      clip_top_q    <= '0;
      clip_width_q  <= '0;
      clip_height_q <= '0;
      surf_width_q  <= '0;
      surf_height_q <= '0;
      row_pitch_q   <= '0;
    end else if (cfg_we_i) begin
      case (gbcb_pkg::cfg_reg_e'(cfg_index_i))
        gbcb_pkg::REG_CLIP_LEFT:      clip_left_q   <= cfg_data_i;
        gbcb_pkg::REG_CLIP_TOP:       clip_top_q    <= cfg_data_i;
        gbcb_pkg::REG_CLIP_WIDTH:     clip_width_q  <= cfg_data_i;
        gbcb_pkg::REG_CLIP_HEIGHT:    clip_height_q <= cfg_data_i;
        gbcb_pkg::REG_SURFACE_WIDTH:  surf_width_q  <= cfg_data_i;
        gbcb_pkg::REG_SURFACE_HEIGHT: surf_height_q <= cfg_data_i;
        gbcb_pkg::REG_ROW_PITCH:      row_pitch_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [gbcb_pkg::CW-1:0] left_raw, top_raw, right_raw, bottom_raw;
  logic signed [gbcb_pkg::CW-1:0] sw_ext, sh_ext;

  always_comb begin
    left_raw   = {{(gbcb_pkg::CW-gbcb_pkg::REG_W){clip_left_q[gbcb_pkg::REG_W-1]}},
                  clip_left_q};
    top_raw    = {{(gbcb_pkg::CW-gbcb_pkg::REG_W){clip_top_q[gbcb_pkg::REG_W-1]}},
                  clip_top_q};
    right_raw  = left_raw + $signed({{(gbcb_pkg::CW-gbcb_pkg::REG_W){1'b0}}, clip_width_q});
    bottom_raw = top_raw + $signed({{(gbcb_pkg::CW-gbcb_pkg::REG_W){1'b0}}, clip_height_q});
    sw_ext     = $signed({{(gbcb_pkg::CW-gbcb_pkg::REG_W){1'b0}}, surf_width_q});
    sh_ext     = $signed({{(gbcb_pkg::CW-gbcb_pkg::REG_W){1'b0}}, surf_height_q});

    // negative near edge raised to zero without moving the far edge; far edge limited to the surface size
    clip_o.left   = left_raw[gbcb_pkg::CW-1] ? '0 : left_raw;
    clip_o.top    = top_raw[gbcb_pkg::CW-1] ? '0 : top_raw;
    clip_o.right  = (right_raw > sw_ext) ? sw_ext : right_raw;
    clip_o.bottom = (bottom_raw > sh_ext) ? sh_ext : bottom_raw;
    clip_o.pitch  = row_pitch_q;
  end

endmodule

// ----- rtl/gbcb_lane.sv -----
// one span lane: is base plus offset inside [lo, hi)
module gbcb_lane (
  input  logic signed [gbcb_pkg::REG_W-1:0] base_i,
  input  logic        [gbcb_pkg::OFS_W-1:0] offset_i,
  input  logic signed [gbcb_pkg::CW-1:0]    lo_i,
  input  logic signed [gbcb_pkg::CW-1:0]    hi_i,
  output logic                              inside_o
);

  logic signed [gbcb_pkg::CW-1:0] pos;

  always_comb begin
    pos = $signed({{(gbcb_pkg::CW-gbcb_pkg::REG_W){base_i[gbcb_pkg::REG_W-1]}}, base_i})
        + $signed({{(gbcb_pkg::CW-gbcb_pkg::OFS_W){1'b0}}, offset_i});
    inside_o = (pos >= lo_i) && (pos < hi_i);
  end

endmodule

// ----- rtl/gbcb_emit.sv -----
// row emitter: one row result per cycle from a loaded block
module gbcb_emit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  gbcb_pkg::load_t                   load_data_i,
  input  logic [gbcb_pkg::REG_W-1:0]        pitch_i,
  output logic                              free_o,
  output logic                              row_valid_o,
  output logic signed [gbcb_pkg::ADDR_W-1:0] row_address_o,
  output logic [gbcb_pkg::MASK_W-1:0]       write_mask_o,
  output logic [gbcb_pkg::COLOR_W-1:0]      pixel_value_o,
  output logic [gbcb_pkg::ROW_W-1:0]        row_number_o,
  output logic                              last_row_o
);

  logic                                             act_q, act_d;
  logic [gbcb_pkg::ROW_W-1:0]                       row_q, row_d;
  logic [gbcb_pkg::EMIT_ROWS-1:0][gbcb_pkg::MASK_W-1:0] masks_q, masks_d;
  logic [gbcb_pkg::ADDR_W-1:0]                      addr_q, addr_d;
  logic [gbcb_pkg::COLOR_W-1:0]                     color_q, color_d;
  logic                                             last;

  assign last   = (row_q == gbcb_pkg::ROW_W'(gbcb_pkg::EMIT_ROWS - 1));
  assign free_o = !act_q || last;

  always_comb begin
    act_d   = act_q;
    row_d   = row_q;
    masks_d = masks_q;
    addr_d  = addr_q;
    color_d = color_q;
    if (load_i) begin
      act_d   = 1'b1;
      row_d   = '0;
      masks_d = load_data_i.masks;
      addr_d  = load_data_i.addr;
      color_d = load_data_i.color;
    end else if (act_q) begin
      if (last) begin
        act_d = 1'b0;
      end else begin
        row_d   = row_q + 1'b1;
        masks_d = masks_q >> gbcb_pkg::MASK_W;
        addr_d  = addr_q + {{(gbcb_pkg::ADDR_W-gbcb_pkg::REG_W){1'b0}}, pitch_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      row_q <= '0;
    end else begin
      act_q <= act_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    masks_q <= masks_d;
    addr_q  <= addr_d;
    color_q <= color_d;
  end

  assign row_valid_o   = act_q;
  assign row_address_o = $signed(addr_q);
  assign write_mask_o  = masks_q[0];
  assign pixel_value_o = color_q;
  assign row_number_o  = row_q;
  assign last_row_o    = act_q && gbcb_pkg::LAST_FLAG_ON
                      && (row_q == gbcb_pkg::ROW_W'(gbcb_pkg::LAST_FLAG_ROW));

endmodule

// ----- rtl/glyph_block_clipped_blit_unit.sv -----
// top level of the clipped glyph block blitter
// a block taken into the capture stage is loaded into the row emitter, whose registers drive its rows
// throughput: a drawn block gives 12 rows, one per cycle, back to back with the next
// block; a culled block leaves the capture stage without waiting; the row emitter sets the pace
// reset: asynchronous active low, clears config and control state, not data; results cannot be stalled
module glyph_block_clipped_blit_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // block requests
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [63:0]                         bits_low_i,
  input  logic [7:0]                          bits_high_i,
  input  logic signed [gbcb_pkg::REG_W-1:0]   pos_x_i,
  input  logic signed [gbcb_pkg::REG_W-1:0]   pos_y_i,
  input  logic [gbcb_pkg::COLOR_W-1:0]        ink_color_i,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gbcb_pkg::IDX_W-1:0]          cfg_index_i,
  input  logic [gbcb_pkg::REG_W-1:0]          cfg_data_i,
  // row results
  output logic                                row_valid_o,
  output logic signed [gbcb_pkg::ADDR_W-1:0]  row_address_o,
  output logic [gbcb_pkg::MASK_W-1:0]         write_mask_o,
  output logic [gbcb_pkg::COLOR_W-1:0]        pixel_value_o,
  output logic [gbcb_pkg::ROW_W-1:0]          row_number_o,
  output logic                                last_row_o
);

  // config port always ready; the user must write only while idle, the block itself does not enforce it
  assign cfg_ready_o = 1'b1;

  gbcb_pkg::clip_t clip;

  gbcb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .clip_o      (clip)
  );

  // capture stage: holds one request while the emitter finishes the previous block
  logic                                cap_valid_q, cap_valid_d;
  logic [gbcb_pkg::GLYPH_BITS-1:0]     glyph_q;
  logic signed [gbcb_pkg::REG_W-1:0]   pos_x_q, pos_y_q;
  logic [gbcb_pkg::COLOR_W-1:0]        color_q;
  logic                                accept, cap_take, load, cull, emit_free;

  // culled blocks leave at once, drawn ones wait for the emitter
  assign cap_take    = cap_valid_q && (cull || emit_free);
  assign load        = cap_valid_q && !cull && emit_free;
  assign busy_o      = cap_valid_q && !cap_take;
  assign accept      = start_i && !busy_o;
  assign cap_valid_d = accept || (cap_valid_q && !cap_take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_valid_q <= 1'b0;
    end else begin
      cap_valid_q <= cap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      glyph_q <= {bits_high_i, bits_low_i};
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      color_q <= ink_color_i;
    end
  end

  // cull test against the effective clip rectangle
  logic signed [gbcb_pkg::CW-1:0] px_w, py_w;
  localparam logic signed [gbcb_pkg::CW-1:0] COLS_S = gbcb_pkg::CW'(gbcb_pkg::BLOCK_COLS);
  localparam logic signed [gbcb_pkg::CW-1:0] ROWS_S = gbcb_pkg::CW'(gbcb_pkg::BLOCK_ROWS);

  always_comb begin
    px_w = {{(gbcb_pkg::CW-gbcb_pkg::REG_W){pos_x_q[gbcb_pkg::REG_W-1]}}, pos_x_q};
    py_w = {{(gbcb_pkg::CW-gbcb_pkg::REG_W){pos_y_q[gbcb_pkg::REG_W-1]}}, pos_y_q};
    cull = (px_w <= clip.left - COLS_S) || (py_w <= clip.top - ROWS_S)
        || (px_w >= clip.right) || (py_w >= clip.bottom);
  end

  // column lanes: horizontal clip test per block column
  logic [gbcb_pkg::MASK_COLS-1:0] col_in;
  for (genvar c = 0; c < gbcb_pkg::MASK_COLS; c++) begin : g_col
    gbcb_lane u_col_lane (
      .base_i   (pos_x_q),
      .offset_i (gbcb_pkg::OFS_W'(c)),
      .lo_i     (clip.left),
      .hi_i     (clip.right),
      .inside_o (col_in[c])
    );
  end

  // row lanes: vertical clip test per emitted row
  logic [gbcb_pkg::EMIT_ROWS-1:0] row_in;
  for (genvar r = 0; r < gbcb_pkg::EMIT_ROWS; r++) begin : g_row
    gbcb_lane u_row_lane (
      .base_i   (pos_y_q),
      .offset_i (gbcb_pkg::OFS_W'(r)),
      .lo_i     (clip.top),
      .hi_i     (clip.bottom),
      .inside_o (row_in[r])
    );
  end

  // merge: glyph bits gated by column and row lanes
  // pixels past the 72 stored bits read as zero through the padding
  logic [gbcb_pkg::PAD_BITS-1:0] glyph_pad;
  gbcb_pkg::load_t               load_data;
  logic signed [26:0]            prod;

  always_comb begin
    glyph_pad = gbcb_pkg::PAD_BITS'({{gbcb_pkg::PAD_BITS{1'b0}}, glyph_q});
    load_data.masks = '0;
    for (int r = 0; r < gbcb_pkg::EMIT_ROWS; r++) begin
      for (int c = 0; c < gbcb_pkg::MASK_COLS; c++) begin
        load_data.masks[r][c] = row_in[r] && col_in[c]
                             && glyph_pad[r*gbcb_pkg::BLOCK_COLS + c];
      end
    end
  end

  // first row address, later rows step by the pitch in the emitter
  assign prod = $signed({{(27-gbcb_pkg::REG_W){pos_y_q[gbcb_pkg::REG_W-1]}}, pos_y_q})
              * $signed({{(27-gbcb_pkg::REG_W){1'b0}}, clip.pitch});
  assign load_data.addr  = prod[gbcb_pkg::ADDR_W-1:0]
                         + {{(gbcb_pkg::ADDR_W-gbcb_pkg::REG_W){pos_x_q[gbcb_pkg::REG_W-1]}},
                            pos_x_q};
  assign load_data.color = color_q;

  gbcb_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .load_data_i   (load_data),
    .pitch_i       (clip.pitch),
    .free_o        (emit_free),
    .row_valid_o   (row_valid_o),
    .row_address_o (row_address_o),
    .write_mask_o  (write_mask_o),
    .pixel_value_o (pixel_value_o),
    .row_number_o  (row_number_o),
    .last_row_o    (last_row_o)
  );

  // rows of one block come out without gaps
  a_rows_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_valid_o && row_number_o != gbcb_pkg::ROW_W'(gbcb_pkg::EMIT_ROWS - 1))
      |=> (row_valid_o && row_number_o == $past(row_number_o) + 1'b1))
    else $error("row sequence broken");

  // a block starts only from a captured request that passed the cull test
  a_first_row_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_valid_o && row_number_o == '0) |-> $past(cap_valid_q && !cull))
    else $error("first row without a drawn request");

  // last row flag only on a valid result
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_row_o |-> row_valid_o)
    else $error("last row flag without a result");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench of the clipped glyph block blitter, directed and random blocks
module testbench;

  localparam int REG_W      = gbcb_pkg::REG_W;
  localparam int ADDR_W     = gbcb_pkg::ADDR_W;
  localparam int MASK_W     = gbcb_pkg::MASK_W;
  localparam int COLOR_W    = gbcb_pkg::COLOR_W;
  localparam int ROW_W      = gbcb_pkg::ROW_W;
  localparam int IDX_W      = gbcb_pkg::IDX_W;
  localparam int BLOCK_COLS = gbcb_pkg::BLOCK_COLS;
  localparam int BLOCK_ROWS = gbcb_pkg::BLOCK_ROWS;
  localparam int MAX_ROWS   = gbcb_pkg::MAX_ROWS;

  // cycles with no request, row or register write before the run is called hung
  localparam int IDLE_LIMIT   = 2000;
  // a culled block leaves no row behind, so give it time to clear the pipe
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_REGS     = 7;
  localparam int PHASES       = 8;
  localparam int PHASE_BLOCKS = 33;

  localparam logic [63:0] ONES_LO = {64{1'b1}};
  localparam logic [7:0]  ONES_HI = 8'hFF;

  // one row write as the blitter should emit it
  typedef struct {
    logic [ADDR_W-1:0]  address;
    logic [MASK_W-1:0]  mask;
    logic [COLOR_W-1:0] color;
    logic [ROW_W-1:0]   row;
    logic               last;
  } row_write_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic [63:0]                bits_low_i;
  logic [7:0]                 bits_high_i;
  logic signed [REG_W-1:0]    pos_x_i;
  logic signed [REG_W-1:0]    pos_y_i;
  logic [COLOR_W-1:0]         ink_color_i;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [IDX_W-1:0]           cfg_index_i;
  logic [REG_W-1:0]           cfg_data_i;
  logic                       row_valid_o;
  logic signed [ADDR_W-1:0]   row_address_o;
  logic [MASK_W-1:0]          write_mask_o;
  logic [COLOR_W-1:0]         pixel_value_o;
  logic [ROW_W-1:0]           row_number_o;
  logic                       last_row_o;

  // rows still owed by the blitter, oldest first
  row_write_t       pending_rows[$];
  row_write_t       next_row;
  // shadow of the clip and surface registers, all zero out of reset
  logic [REG_W-1:0] clip_regs [NUM_REGS] = '{default: '0};
  int               error_count = 0;

  glyph_block_clipped_blit_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .bits_low_i    (bits_low_i),
    .bits_high_i   (bits_high_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .ink_color_i   (ink_color_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .row_valid_o   (row_valid_o),
    .row_address_o (row_address_o),
    .write_mask_o  (write_mask_o),
    .pixel_value_o (pixel_value_o),
    .row_number_o  (row_number_o),
    .last_row_o    (last_row_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // works out the row writes of one block under the current clip
  function automatic void predict_block(input logic [63:0] lo, input logic [7:0] hi,
                                        input logic signed [REG_W-1:0] x0,
                                        input logic signed [REG_W-1:0] y0,
                                        input logic [COLOR_W-1:0] ink);
    logic [71:0] glyph;
    int          left, top, right, bottom, pitch, py, px, k, surf_w, surf_h;
    longint      addr;
    row_write_t  w;
    glyph  = {hi, lo};
    left   = int'($signed(clip_regs[gbcb_pkg::REG_CLIP_LEFT]));
    top    = int'($signed(clip_regs[gbcb_pkg::REG_CLIP_TOP]));
    right  = left + int'(clip_regs[gbcb_pkg::REG_CLIP_WIDTH]);
    bottom = top + int'(clip_regs[gbcb_pkg::REG_CLIP_HEIGHT]);
    pitch  = int'(clip_regs[gbcb_pkg::REG_ROW_PITCH]);
    surf_w = int'(clip_regs[gbcb_pkg::REG_SURFACE_WIDTH]);
    surf_h = int'(clip_regs[gbcb_pkg::REG_SURFACE_HEIGHT]);
    // negative origin is pulled to 0, far edge stays put but is limited to the surface size
    if (left < 0) left = 0;
    if (top < 0) top = 0;
    if (right > surf_w) right = surf_w;
    if (bottom > surf_h) bottom = surf_h;
    // no overlap at all: the block is dropped
    if (int'(x0) <= left - BLOCK_COLS || int'(y0) <= top - BLOCK_ROWS ||
        int'(x0) >= right || int'(y0) >= bottom) return;
    for (int r = 0; r < BLOCK_ROWS && r < MAX_ROWS; r++) begin
      py        = int'(y0) + r;
      addr      = longint'(x0) + longint'(py) * longint'(pitch);
      w.address = addr[ADDR_W-1:0];
      w.mask    = '0;
      for (int c = 0; c < BLOCK_COLS && c < MASK_W; c++) begin
        px = int'(x0) + c;
        k  = r * BLOCK_COLS + c;
        if (py >= top && py < bottom && px >= left && px < right && k < 72 && glyph[k])
          w.mask[c] = 1'b1;
      end
      w.color = ink;
      w.row   = ROW_W'(r);
      w.last  = (r == BLOCK_ROWS - 1);
      pending_rows.push_back(w);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // row checker, every strobed row is taken at the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && row_valid_o) begin
      if (pending_rows.size() == 0) begin
        $error("row result with nothing expected: address 0x%0h row %0d",
               row_address_o, row_number_o);
        error_count++;
      end else begin
        next_row = pending_rows.pop_front();
        check_field("row_address", 32'(next_row.address), 32'($unsigned(row_address_o)));
        check_field("write_mask", 32'(next_row.mask), 32'(write_mask_o));
        check_field("pixel_value", 32'(next_row.color), 32'(pixel_value_o));
        check_field("row_number", 32'(next_row.row), 32'(row_number_o));
        check_field("last_row", 32'(next_row.last), 32'(last_row_o));
      end
    end
  end

  // watchdog, restarts on any accepted request, row or register write
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || row_valid_o || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("glyph_block_clipped_blit_unit test failed");
    $finish;
  end

  // drives one block request and holds it until the blitter takes it
  task automatic send_block(input logic [63:0] lo, input logic [7:0] hi,
                            input logic signed [REG_W-1:0] x0,
                            input logic signed [REG_W-1:0] y0,
                            input logic [COLOR_W-1:0] ink);
    @(negedge clk_i);
    start_i     = 1'b1;
    bits_low_i  = lo;
    bits_high_i = hi;
    pos_x_i     = x0;
    pos_y_i     = y0;
    ink_color_i = ink;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    predict_block(lo, hi, x0, y0, ink);
  endtask

  // start low for the given number of cycles
  task automatic pause_sender(input int cycles);
    if (cycles == 0) return;
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // stop sending and wait for every owed row
  task automatic wait_drained();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_rows.size() != 0) @(negedge clk_i);
  endtask

  // blitter fully idle, safe for register writes
  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input gbcb_pkg::cfg_reg_e idx, input logic [REG_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    clip_regs[idx] = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_clip(input logic [REG_W-1:0] left, input logic [REG_W-1:0] top,
                           input logic [REG_W-1:0] width, input logic [REG_W-1:0] height,
                           input logic [REG_W-1:0] surf_w, input logic [REG_W-1:0] surf_h,
                           input logic [REG_W-1:0] pitch);
    settle();
    write_reg(gbcb_pkg::REG_CLIP_LEFT, left);
    write_reg(gbcb_pkg::REG_CLIP_TOP, top);
    write_reg(gbcb_pkg::REG_CLIP_WIDTH, width);
    write_reg(gbcb_pkg::REG_CLIP_HEIGHT, height);
    write_reg(gbcb_pkg::REG_SURFACE_WIDTH, surf_w);
    write_reg(gbcb_pkg::REG_SURFACE_HEIGHT, surf_h);
    write_reg(gbcb_pkg::REG_ROW_PITCH, pitch);
  endtask

  // reset clip is zero sized at the origin: only blocks straddling it survive the cull
  task automatic test_reset_clip();
    send_block(ONES_LO, ONES_HI, -3, -5, 16'h1234);
    send_block(ONES_LO, ONES_HI, 0, 0, 16'h1234);
    send_block(ONES_LO, ONES_HI, -6, -1, 16'h1234);
  endtask

  // each clip edge, one pixel inside and one pixel past the cull line
  task automatic test_clip_edges();
    load_clip(0, 0, 64, 48, 64, 48, 64);
    send_block(ONES_LO, ONES_HI, 10, 10, 16'hFFFF);
    send_block(64'h0, 8'h0, 10, 10, 16'h0000);
    send_block(64'hAAAA_5555_3C3C_C3C3, 8'h5A, -5, 5, 16'hA5A5);
    send_block(ONES_LO, ONES_HI, -6, 5, 16'hA5A5);
    send_block(64'h5555_AAAA_0F0F_F0F0, 8'hA5, 63, 5, 16'h5A5A);
    send_block(ONES_LO, ONES_HI, 64, 5, 16'h5A5A);
    send_block(ONES_LO, ONES_HI, 5, -11, 16'h0F0F);
    send_block(ONES_LO, ONES_HI, 5, -12, 16'h0F0F);
    send_block(ONES_LO, ONES_HI, 5, 47, 16'hF0F0);
    send_block(ONES_LO, ONES_HI, 5, 48, 16'hF0F0);
  endtask

  // negative origin keeps the far edge, and a zero sized clip still emits masked-off rows
  task automatic test_clip_origin();
    load_clip(-10, -20, 30, 40, 4096, 4096, 100);
    send_block(ONES_LO, ONES_HI, 15, 15, 16'h7E7E);
    send_block(ONES_LO, ONES_HI, 20, 0, 16'h7E7E);
    load_clip(5, 5, 0, 0, 64, 64, 64);
    send_block(ONES_LO, ONES_HI, 2, 2, 16'h8181);
    send_block(ONES_LO, ONES_HI, 5, 5, 16'h8181);
  endtask

  // register and position extremes, including a negative row address that wraps below the origin
  task automatic test_wide_range();
    load_clip(-4096, -4096, 4096, 4096, 4096, 4096, 4096);
    send_block(ONES_LO, ONES_HI, -2, -2, 16'h3333);
    load_clip(0, 0, 4096, 4096, 4096, 4096, 4096);
    send_block(ONES_LO, ONES_HI, 4095, 4095, 16'hCCCC);
    send_block(ONES_LO, ONES_HI, -5, -11, 16'hCCCC);
    send_block(ONES_LO, ONES_HI, -4096, -4096, 16'hCCCC);
    load_clip(4095, 4095, 4096, 4096, 4096, 4096, 0);
    send_block(ONES_LO, ONES_HI, 4095, 4095, 16'h9999);
  endtask

  // random clips, blocks mostly aimed at the clip window, sent in bursts
  task automatic test_random_blocks();
    int                      burst, x_lo, y_lo, x_span, y_span, pick;
    logic [63:0]             lo;
    logic [7:0]              hi;
    logic signed [REG_W-1:0] x0, y0;
    burst = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase % 4 == 0)
        load_clip(REG_W'($urandom_range(0, 8191)), REG_W'($urandom_range(0, 8191)),
                  REG_W'($urandom_range(0, 4096)), REG_W'($urandom_range(0, 4096)),
                  REG_W'($urandom_range(0, 4096)), REG_W'($urandom_range(0, 4096)),
                  REG_W'($urandom_range(0, 4096)));
      else
        load_clip(REG_W'(int'($urandom_range(0, 200)) - 60),
                  REG_W'(int'($urandom_range(0, 200)) - 60),
                  REG_W'($urandom_range(0, 160)), REG_W'($urandom_range(0, 160)),
                  REG_W'($urandom_range(0, 300)), REG_W'($urandom_range(0, 300)),
                  REG_W'($urandom_range(0, 4096)));
      // window a little wider than the unclamped clip rectangle
      x_lo   = int'($signed(clip_regs[gbcb_pkg::REG_CLIP_LEFT])) - 8;
      y_lo   = int'($signed(clip_regs[gbcb_pkg::REG_CLIP_TOP])) - 14;
      x_span = int'(clip_regs[gbcb_pkg::REG_CLIP_WIDTH]) + 10;
      y_span = int'(clip_regs[gbcb_pkg::REG_CLIP_HEIGHT]) + 16;
      for (int i = 0; i < PHASE_BLOCKS; i++) begin
        // one phase runs back to back, the others in bursts with gaps
        if (burst == 0) begin
          pick = $urandom_range(0, 3);
          if (phase != 5) pause_sender(pick == 0 ? 0 : $urandom_range(1, 12));
          burst = $urandom_range(1, 10);
        end
        burst--;
        if (phase == 2 && i == PHASE_BLOCKS / 2) wait_drained();
        pick = $urandom_range(0, 5);
        if (pick == 0) begin
          lo = ONES_LO;
          hi = ONES_HI;
        end else if (pick == 1) begin
          lo = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
          hi = 8'($urandom) & 8'($urandom);
        end else begin
          lo = {$urandom, $urandom};
          hi = 8'($urandom);
        end
        if ($urandom_range(0, 3) == 0) begin
          x0 = REG_W'($urandom);
          y0 = REG_W'($urandom);
        end else begin
          x0 = REG_W'(x_lo + int'($urandom_range(0, x_span)));
          y0 = REG_W'(y_lo + int'($urandom_range(0, y_span)));
        end
        send_block(lo, hi, x0, y0, 16'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    bits_low_i  = '0;
    bits_high_i = '0;
    pos_x_i     = '0;
    pos_y_i     = '0;
    ink_color_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = gbcb_pkg::REG_CLIP_LEFT;
    cfg_data_i  = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_clip();
    test_clip_edges();
    test_clip_origin();
    test_wide_range();
    test_random_blocks();
    settle();
    if (error_count == 0 && pending_rows.size() == 0)
      $display("glyph_block_clipped_blit_unit test passed");
    else
      $display("glyph_block_clipped_blit_unit test failed");
    $finish;
  end

endmodule
